/* hdl/pwrma_pkg.sv */
// Shared types, widths, codes and reset values for the power percent filter.
`timescale 1ns / 1ps

package pwrma_pkg;

  localparam int DATA_W      = 16;
  localparam int SUM_W       = 25;
  localparam int WL_W        = 8;
  localparam int REGEN_W     = 8;
  localparam int STS_W       = 2;
  localparam int IDX_W       = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;

  localparam int MAX_WINDOW_DEF = 256;

  localparam logic [STS_W-1:0] STS_VALID   = 2'd0;
  localparam logic [STS_W-1:0] STS_UNKNOWN = 2'd2;

  localparam int                       WL_RESET        = 8;
  localparam logic signed [DATA_W-1:0] RANGE_MIN_RESET = -16'sd100;
  localparam logic signed [DATA_W-1:0] RANGE_MAX_RESET = 16'sd100;
  localparam logic signed [DATA_W-1:0] DEAD_MIN_RESET  = 16'sd0;
  localparam logic signed [DATA_W-1:0] DEAD_MAX_RESET  = 16'sd0;
  localparam logic signed [DATA_W-1:0] INIT_RESET      = 16'sd0;
  localparam logic signed [REGEN_W-1:0] REGEN_RESET    = 8'sd0;
  localparam logic [DATA_W-1:0]        OUTPUT_RESET    = 16'd0;
  localparam logic signed [SUM_W-1:0]  SUM_RESET       = 25'(INIT_RESET * WL_RESET);
  localparam logic [IDX_W-1:0]         OLDEST_RESET    = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WINDOW_LENGTH  = 3'd0,
    CFG_RANGE_MIN      = 3'd1,
    CFG_RANGE_MAX      = 3'd2,
    CFG_DEAD_MIN       = 3'd3,
    CFG_DEAD_MAX       = 3'd4,
    CFG_INIT_VALUE     = 3'd5,
    CFG_REGEN_DEFAULT  = 3'd6,
    CFG_OUTPUT_DEFAULT = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FILL,
    ST_RMW,
    ST_SUM,
    ST_DIVS,
    ST_DIVW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* hdl/pwrma_ring.sv */
// Sample ring: single-port synchronous RAM, read-first, with registered read data.
`timescale 1ns / 1ps

module pwrma_ring #(
  parameter int DEPTH = pwrma_pkg::MAX_WINDOW_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [AW-1:0]                         addr,
  input  logic signed [pwrma_pkg::DATA_W-1:0]   wdata,
  output logic signed [pwrma_pkg::DATA_W-1:0]   rdata
);

  logic signed [pwrma_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [pwrma_pkg::DATA_W-1:0] rdata_r;

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pwrma_div.sv */
// Radix-2 restoring divider: signed window sum over window length, truncating.
`timescale 1ns / 1ps

module pwrma_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [pwrma_pkg::SUM_W-1:0]   dividend,
  input  logic [pwrma_pkg::WL_W-1:0]           divisor,
  output pwrma_pkg::div_sts_t                  sts,
  output logic signed [pwrma_pkg::DATA_W-1:0]  quotient
);

  localparam int SW    = pwrma_pkg::SUM_W;
  localparam int DW    = pwrma_pkg::WL_W;
  localparam int QW    = pwrma_pkg::DATA_W;
  localparam int CNT_W = $clog2(SW);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r, d_r;
  logic [SW-1:0]    q_r;
  logic             neg_r;

  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;
  logic [SW-1:0]    mag;
  logic [QW-1:0]    q_lo;

  assign mag     = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
  assign shifted = {rem_r, q_r[SW-1]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = shifted >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= mag;
      d_r   <= divisor;
      neg_r <= dividend[SW-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      q_r   <= {q_r[SW-2:0], ge};
    end
  end

  // only the low bits survive the wrap to the result width
  assign q_lo     = q_r[QW-1:0];
  assign quotient = neg_r ? $signed(~q_lo + QW'(1)) : $signed(q_lo);
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

/* hdl/power_pct_validate_moving_average.sv */
// Top level: power percent check, limit substitution and boxcar moving average.
`timescale 1ns / 1ps

// Each request checks a power percent sample against the range and dead band,
// substitutes defaults for limits whose status is not valid and updates a
// boxcar average whose samples live in a single-port ring RAM of MAX_WINDOW
// entries. One result comes out per request. A request either passes the
// sample through to the average, updates the ring (read-modify-write of the
// oldest entry and the sum update, then start and run the 25-step
// bit-serial divider) or refills the ring, writing one entry per cycle on
// the single RAM port; the window here is min(window_length, MAX_WINDOW).
// After reset the ring is first filled with min(8, MAX_WINDOW) copies of the
// init value while in_tready stays low; configuration writes are taken
// during that time. A finished result may wait in the output register while
// the next request is taken.
module power_pct_validate_moving_average #(
  parameter int MAX_WINDOW = pwrma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // fields from bit 0: ignition_on, power_status, power_raw, regen_status,
  // regen_raw, output_status, output_raw, zero pad
  input  logic [pwrma_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: filtered_power, instant_power, power_state,
  // regen_limit, regen_state, output_limit, output_state, zero pad
  output logic [pwrma_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_wr_en,
  input  logic [pwrma_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [pwrma_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int DW  = pwrma_pkg::DATA_W;
  localparam int SW  = pwrma_pkg::SUM_W;
  localparam int WW  = pwrma_pkg::WL_W;
  localparam int RW  = pwrma_pkg::REGEN_W;
  localparam int STW = pwrma_pkg::STS_W;
  localparam int IW  = pwrma_pkg::IDX_W;
  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int RST_LEN = (pwrma_pkg::WL_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                              : pwrma_pkg::WL_RESET;

  // configuration
  logic [WW-1:0]        wl_r;
  logic signed [DW-1:0] rmin_r, rmax_r, dmin_r, dmax_r, init_r;
  logic signed [RW-1:0] regen_def_r;
  logic [DW-1:0]        out_def_r;

  // latched request fields
  logic                 ign_r;
  logic [STW-1:0]       psts_r, rsts_r, osts_r;
  logic signed [DW-1:0] praw_r;
  logic signed [RW-1:0] rraw_r;
  logic [DW-1:0]        oraw_r;

  // filter and signal state
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic signed [DW-1:0] avg_r, avg_nxt;
  logic [IW-1:0]        oldest_r, oldest_nxt;
  logic signed [DW-1:0] inst_r, inst_nxt;
  logic signed [RW-1:0] regen_r, regen_nxt;
  logic [DW-1:0]        outlim_r, outlim_nxt;
  logic [STW-1:0]       pwr_sts_r, pwr_sts_nxt;
  logic [STW-1:0]       rgn_sts_r, rgn_sts_nxt;
  logic [STW-1:0]       olim_sts_r, olim_sts_nxt;

  // sequencing
  pwrma_pkg::state_t    state_r, state_nxt;
  logic                 boot_r, boot_nxt;
  logic [CW-1:0]        fill_cnt_r, fill_cnt_nxt;
  logic [CW-1:0]        fill_len_r, fill_len_nxt;
  logic signed [DW-1:0] fill_val_r, fill_val_nxt;
  logic signed [DW-1:0] feed_val_r, feed_val_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;

  logic                          out_valid_r;
  logic [pwrma_pkg::OUT_TDATA_W-1:0] out_data_r;

  // datapath helpers
  logic                 in_acc;
  logic [CW-1:0]        eff_w;
  logic                 eff_gt1;
  logic                 in_range, in_dead;
  logic signed [DW-1:0] chk_f, chk_inst;
  logic                 pwr_ok;
  logic                 do_fill;
  logic signed [DW-1:0] fill_src;
  logic signed [SW-1:0] fill_prod;
  logic                 fill_last;

  logic                 ring_we;
  logic [AW-1:0]        ring_addr;
  logic signed [DW-1:0] ring_wdata, ring_rd;

  logic                 div_start;
  pwrma_pkg::div_sts_t  div_sts;
  logic signed [DW-1:0] div_q;
  logic                 out_load;

  assign in_acc = in_tvalid && in_tready;

  assign eff_w   = (32'(wl_r) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(wl_r);
  assign eff_gt1 = 32'(eff_w) > 32'd1;

  assign in_range = (praw_r <= rmax_r) && (praw_r >= rmin_r);
  assign in_dead  = ((praw_r <= dmax_r) && (praw_r >= dmin_r)) || (praw_r == rmin_r);
  assign chk_f    = (in_range && !in_dead) ? praw_r : '0;
  assign chk_inst = in_range ? praw_r : '0;

  assign pwr_ok    = ign_r && (psts_r == pwrma_pkg::STS_VALID);
  assign do_fill   = !pwr_ok || (pwr_sts_r != pwrma_pkg::STS_VALID);
  assign fill_src  = pwr_ok ? chk_f : init_r;
  assign fill_prod = fill_src * $signed({1'b0, wl_r});
  assign fill_last = CW'(fill_cnt_r + 1'b1) == fill_len_r;

  pwrma_ring #(
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .wr_en (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rd)
  );

  pwrma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (wl_r),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= WW'(pwrma_pkg::WL_RESET);
      rmin_r      <= pwrma_pkg::RANGE_MIN_RESET;
      rmax_r      <= pwrma_pkg::RANGE_MAX_RESET;
      dmin_r      <= pwrma_pkg::DEAD_MIN_RESET;
      dmax_r      <= pwrma_pkg::DEAD_MAX_RESET;
      init_r      <= pwrma_pkg::INIT_RESET;
      regen_def_r <= pwrma_pkg::REGEN_RESET;
      out_def_r   <= pwrma_pkg::OUTPUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (pwrma_pkg::cfg_idx_t'(cfg_addr))
        pwrma_pkg::CFG_WINDOW_LENGTH:  wl_r        <= cfg_wdata[WW-1:0];
        pwrma_pkg::CFG_RANGE_MIN:      rmin_r      <= $signed(cfg_wdata);
        pwrma_pkg::CFG_RANGE_MAX:      rmax_r      <= $signed(cfg_wdata);
        pwrma_pkg::CFG_DEAD_MIN:       dmin_r      <= $signed(cfg_wdata);
        pwrma_pkg::CFG_DEAD_MAX:       dmax_r      <= $signed(cfg_wdata);
        pwrma_pkg::CFG_INIT_VALUE:     init_r      <= $signed(cfg_wdata);
        pwrma_pkg::CFG_REGEN_DEFAULT:  regen_def_r <= $signed(cfg_wdata[RW-1:0]);
        pwrma_pkg::CFG_OUTPUT_DEFAULT: out_def_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pwrma_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = pwrma_pkg::ST_EVAL;
      end
      pwrma_pkg::ST_EVAL: begin
        if (do_fill) begin
          state_nxt = (eff_w == '0) ? pwrma_pkg::ST_DONE : pwrma_pkg::ST_FILL;
        end else if (eff_gt1) begin
          state_nxt = pwrma_pkg::ST_RMW;
        end else begin
          state_nxt = pwrma_pkg::ST_DONE;
        end
      end
      pwrma_pkg::ST_FILL: begin
        if (fill_last) state_nxt = boot_r ? pwrma_pkg::ST_IDLE : pwrma_pkg::ST_DONE;
      end
      pwrma_pkg::ST_RMW:  state_nxt = pwrma_pkg::ST_SUM;
      pwrma_pkg::ST_SUM:  state_nxt = pwrma_pkg::ST_DIVS;
      pwrma_pkg::ST_DIVS: state_nxt = pwrma_pkg::ST_DIVW;
      pwrma_pkg::ST_DIVW: begin
        if (div_sts.done) state_nxt = pwrma_pkg::ST_DONE;
      end
      pwrma_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = pwrma_pkg::ST_IDLE;
      end
      default: state_nxt = pwrma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    ring_we    = 1'b0;
    ring_addr  = idx_r[AW-1:0];
    ring_wdata = feed_val_r;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      pwrma_pkg::ST_IDLE: in_tready = 1'b1;
      pwrma_pkg::ST_FILL: begin
        ring_we    = 1'b1;
        ring_addr  = fill_cnt_r[AW-1:0];
        ring_wdata = fill_val_r;
      end
      pwrma_pkg::ST_RMW:  ring_we = 1'b1;
      pwrma_pkg::ST_DIVS: div_start = 1'b1;
      pwrma_pkg::ST_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // filter and signal updates
  always_comb begin
    sum_nxt      = sum_r;
    avg_nxt      = avg_r;
    oldest_nxt   = oldest_r;
    inst_nxt     = inst_r;
    regen_nxt    = regen_r;
    outlim_nxt   = outlim_r;
    pwr_sts_nxt  = pwr_sts_r;
    rgn_sts_nxt  = rgn_sts_r;
    olim_sts_nxt = olim_sts_r;
    boot_nxt     = boot_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_len_nxt = fill_len_r;
    fill_val_nxt = fill_val_r;
    feed_val_nxt = feed_val_r;
    idx_nxt      = idx_r;
    case (state_r)
      pwrma_pkg::ST_EVAL: begin
        inst_nxt = pwr_ok ? chk_inst : init_r;
        if (ign_r) begin
          regen_nxt    = (rsts_r == pwrma_pkg::STS_VALID) ? rraw_r : regen_def_r;
          outlim_nxt   = (osts_r == pwrma_pkg::STS_VALID) ? oraw_r : out_def_r;
          pwr_sts_nxt  = psts_r;
          rgn_sts_nxt  = rsts_r;
          olim_sts_nxt = osts_r;
        end else begin
          regen_nxt    = regen_def_r;
          outlim_nxt   = out_def_r;
          pwr_sts_nxt  = pwrma_pkg::STS_UNKNOWN;
          rgn_sts_nxt  = pwrma_pkg::STS_UNKNOWN;
          olim_sts_nxt = pwrma_pkg::STS_UNKNOWN;
        end
        if (do_fill) begin
          sum_nxt      = fill_prod;
          avg_nxt      = fill_src;
          oldest_nxt   = pwrma_pkg::OLDEST_RESET;
          fill_val_nxt = fill_src;
          fill_cnt_nxt = '0;
          fill_len_nxt = eff_w;
        end else if (eff_gt1) begin
          feed_val_nxt = chk_f;
          idx_nxt      = (32'(oldest_r) >= 32'(eff_w)) ? '0 : oldest_r;
        end else begin
          avg_nxt = chk_f;
        end
      end
      pwrma_pkg::ST_FILL: begin
        fill_cnt_nxt = CW'(fill_cnt_r + 1'b1);
        if (fill_last) boot_nxt = 1'b0;
      end
      pwrma_pkg::ST_SUM: begin
        // drop the oldest sample, add the new one; wraps to the sum width
        sum_nxt    = sum_r - SW'(ring_rd) + SW'(feed_val_r);
        oldest_nxt = IW'(idx_r + 1'b1);
      end
      pwrma_pkg::ST_DIVW: begin
        if (div_sts.done) avg_nxt = div_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwrma_pkg::ST_FILL;
      boot_r      <= 1'b1;
      fill_cnt_r  <= '0;
      fill_len_r  <= CW'(RST_LEN);
      fill_val_r  <= pwrma_pkg::INIT_RESET;
      sum_r       <= pwrma_pkg::SUM_RESET;
      avg_r       <= pwrma_pkg::INIT_RESET;
      oldest_r    <= pwrma_pkg::OLDEST_RESET;
      inst_r      <= pwrma_pkg::INIT_RESET;
      regen_r     <= pwrma_pkg::REGEN_RESET;
      outlim_r    <= pwrma_pkg::OUTPUT_RESET;
      pwr_sts_r   <= pwrma_pkg::STS_UNKNOWN;
      rgn_sts_r   <= pwrma_pkg::STS_UNKNOWN;
      olim_sts_r  <= pwrma_pkg::STS_UNKNOWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_len_r  <= fill_len_nxt;
      fill_val_r  <= fill_val_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      oldest_r    <= oldest_nxt;
      inst_r      <= inst_nxt;
      regen_r     <= regen_nxt;
      outlim_r    <= outlim_nxt;
      pwr_sts_r   <= pwr_sts_nxt;
      rgn_sts_r   <= rgn_sts_nxt;
      olim_sts_r  <= olim_sts_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    feed_val_r <= feed_val_nxt;
    idx_r      <= idx_nxt;
    if (in_acc) begin
      ign_r  <= in_tdata[0];
      psts_r <= in_tdata[2:1];
      praw_r <= $signed(in_tdata[18:3]);
      rsts_r <= in_tdata[20:19];
      rraw_r <= $signed(in_tdata[28:21]);
      osts_r <= in_tdata[30:29];
      oraw_r <= in_tdata[46:31];
    end
    if (out_load) begin
      out_data_r <= {2'b00, olim_sts_r, outlim_r, rgn_sts_r, regen_r,
                     pwr_sts_r, inst_r, avg_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == pwrma_pkg::ST_DIVW)
    else $error("divider result arrived outside its wait state");

  a_fill_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwrma_pkg::ST_FILL |-> fill_cnt_r < fill_len_r)
    else $error("ring fill ran past its length");

  a_rmw_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pwrma_pkg::ST_RMW |=> state_r == pwrma_pkg::ST_SUM && !in_tready)
    else $error("ring read data not consumed in the following cycle");

endmodule
